>>> src/heu_pkg.sv
// shared types, trie node codes and lookup functions for the entity decoder
// no dependencies; imported by every module of the block
package heu_pkg;

  // default depth of the command queue between front and back
  localparam int unsigned CmdDepthDefault = 4;

  // character codes
  localparam logic [7:0] ChAnd   = 8'h26;
  localparam logic [7:0] ChA     = 8'h61;
  localparam logic [7:0] ChL     = 8'h6c;
  localparam logic [7:0] ChG     = 8'h67;
  localparam logic [7:0] ChQ     = 8'h71;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChM     = 8'h6d;
  localparam logic [7:0] ChP     = 8'h70;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChO     = 8'h6f;
  localparam logic [7:0] Ch3     = 8'h33;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChDquot = 8'h22;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChLt    = 8'h3c;
  localparam logic [7:0] ChGt    = 8'h3e;

  // trie nodes: each names the entity prefix held so far
  typedef enum logic [3:0] {
    ND_IDLE   = 4'd0,
    ND_AND    = 4'd1,
    ND_A      = 4'd2,
    ND_AM     = 4'd3,
    ND_AMP    = 4'd4,
    ND_L      = 4'd5,
    ND_LT     = 4'd6,
    ND_G      = 4'd7,
    ND_GT     = 4'd8,
    ND_Q      = 4'd9,
    ND_QU     = 4'd10,
    ND_QUO    = 4'd11,
    ND_QUOT   = 4'd12,
    ND_HASH   = 4'd13,
    ND_HASH3  = 4'd14,
    ND_HASH39 = 4'd15
  } heu_node_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_text;
  } heu_in_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       final_out;
  } heu_out_t;

  // at most one command per accepted byte: flush a held prefix, then an optional byte
  typedef struct packed {
    heu_node_e  flush_node;
    logic       mid_valid;
    logic [7:0] mid_byte;
    logic       last;
  } heu_cmd_t;

  // number of bytes held by a node
  function automatic logic [2:0] held_len(input heu_node_e node);
    logic [2:0] len;
    case (node)
      ND_IDLE:                              len = 3'd0;
      ND_AND:                               len = 3'd1;
      ND_A, ND_L, ND_G, ND_Q, ND_HASH:      len = 3'd2;
      ND_AM, ND_LT, ND_GT, ND_QU, ND_HASH3: len = 3'd3;
      ND_AMP, ND_QUO, ND_HASH39:            len = 3'd4;
      ND_QUOT:                              len = 3'd5;
      default:                              len = 3'd0;
    endcase
    return len;
  endfunction

  // held bytes of a node, first byte in the low lane
  function automatic logic [39:0] held_text(input heu_node_e node);
    logic [39:0] txt;
    case (node)
      ND_IDLE:   txt = '0;
      ND_AND:    txt = {32'h0, ChAnd};
      ND_A:      txt = {24'h0, ChA, ChAnd};
      ND_AM:     txt = {16'h0, ChM, ChA, ChAnd};
      ND_AMP:    txt = {8'h0, ChP, ChM, ChA, ChAnd};
      ND_L:      txt = {24'h0, ChL, ChAnd};
      ND_LT:     txt = {16'h0, ChT, ChL, ChAnd};
      ND_G:      txt = {24'h0, ChG, ChAnd};
      ND_GT:     txt = {16'h0, ChT, ChG, ChAnd};
      ND_Q:      txt = {24'h0, ChQ, ChAnd};
      ND_QU:     txt = {16'h0, ChU, ChQ, ChAnd};
      ND_QUO:    txt = {8'h0, ChO, ChU, ChQ, ChAnd};
      ND_QUOT:   txt = {ChT, ChO, ChU, ChQ, ChAnd};
      ND_HASH:   txt = {24'h0, ChHash, ChAnd};
      ND_HASH3:  txt = {16'h0, Ch3, ChHash, ChAnd};
      ND_HASH39: txt = {8'h0, Ch9, Ch3, ChHash, ChAnd};
      default:   txt = '0;
    endcase
    return txt;
  endfunction

  // one held byte of a node by position
  function automatic logic [7:0] held_char(input heu_node_e node, input logic [2:0] idx);
    logic [39:0] txt;
    logic [7:0]  ch;
    txt = held_text(node);
    case (idx)
      3'd0:    ch = txt[7:0];
      3'd1:    ch = txt[15:8];
      3'd2:    ch = txt[23:16];
      3'd3:    ch = txt[31:24];
      3'd4:    ch = txt[39:32];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // byte that advances a node of depth two or more
  function automatic logic [7:0] next_byte(input heu_node_e node);
    logic [7:0] ch;
    case (node)
      ND_A:                                       ch = ChM;
      ND_AM:                                      ch = ChP;
      ND_L, ND_G:                                 ch = ChT;
      ND_Q:                                       ch = ChU;
      ND_QU:                                      ch = ChO;
      ND_QUO:                                     ch = ChT;
      ND_HASH:                                    ch = Ch3;
      ND_HASH3:                                   ch = Ch9;
      ND_AMP, ND_LT, ND_GT, ND_QUOT, ND_HASH39:   ch = ChSemi;
      default:                                    ch = 8'h00;
    endcase
    return ch;
  endfunction

  // replacement byte of nodes that complete an entity on ';'
  function automatic logic [7:0] repl_byte(input heu_node_e node);
    logic [7:0] ch;
    case (node)
      ND_AMP:    ch = ChAnd;
      ND_LT:     ch = ChLt;
      ND_GT:     ch = ChGt;
      ND_QUOT:   ch = ChDquot;
      ND_HASH39: ch = ChApos;
      default:   ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

>>> src/heu_front.sv
// front end: trie walk over the input bytes, at most one command per transaction
// depends on heu_pkg
module heu_front import heu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  heu_in_t  in_data_i,
  output logic     cmd_push_o,
  output heu_cmd_t cmd_o
);

  heu_node_e match_node_q, match_node_d;
  heu_node_e nxt;
  logic      advanced;
  logic [7:0] ch;
  logic       last;

  assign ch   = in_data_i.char_in;
  assign last = in_data_i.end_of_text;

  // trie step
  always_comb begin
    advanced = 1'b0;
    nxt      = ND_IDLE;
    if (match_node_q == ND_AND) begin
      advanced = 1'b1;
      case (ch)
        ChA:     nxt = ND_A;
        ChL:     nxt = ND_L;
        ChG:     nxt = ND_G;
        ChQ:     nxt = ND_Q;
        ChHash:  nxt = ND_HASH;
        default: advanced = 1'b0;
      endcase
    end else if (match_node_q != ND_IDLE && ch == next_byte(match_node_q)) begin
      advanced = 1'b1;
      if (repl_byte(match_node_q) != 8'h00) begin
        nxt = ND_IDLE;
      end else begin
        nxt = heu_node_e'(match_node_q + 4'd1);
      end
    end
    // a byte that breaks the match starts a new one if it is '&'
    if (!advanced && ch == ChAnd) begin
      nxt = ND_AND;
    end
  end

  // classify into a command: a broken prefix flushes, a pending one flushes at the end
  always_comb begin
    cmd_o.last = last;
    if (advanced) begin
      if (nxt == ND_IDLE) begin
        cmd_o.flush_node = ND_IDLE;
        cmd_o.mid_valid  = 1'b1;
        cmd_o.mid_byte   = repl_byte(match_node_q);
      end else begin
        cmd_o.flush_node = last ? nxt : ND_IDLE;
        cmd_o.mid_valid  = 1'b0;
        cmd_o.mid_byte   = ch;
      end
    end else begin
      // a new '&' at the end flushes as itself
      cmd_o.flush_node = match_node_q;
      cmd_o.mid_valid  = (ch != ChAnd) || last;
      cmd_o.mid_byte   = ch;
    end
  end

  assign cmd_push_o = accept_i && (cmd_o.mid_valid || cmd_o.flush_node != ND_IDLE);

  always_comb begin
    match_node_d = match_node_q;
    if (accept_i) begin
      match_node_d = last ? ND_IDLE : nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_node_q <= ND_IDLE;
    end else begin
      match_node_q <= match_node_d;
    end
  end

  // end of text always leaves the trie idle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last |=> match_node_q == ND_IDLE)
    else $error("trie not idle after end of text");

endmodule

>>> src/heu_cmd_fifo.sv
// command queue between front and back
// depends on heu_pkg
module heu_cmd_fifo import heu_pkg::*; #(
  parameter int unsigned Depth = CmdDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  heu_cmd_t cmd_i,
  input  logic     pop_i,
  output heu_cmd_t head_o,
  output logic     empty_o,
  output logic     full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  heu_cmd_t            mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                do_push, do_pop;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntFull);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = mem_q[rd_ptr_q];

  // pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntFull)
    else $error("command queue overfilled");

endmodule

>>> src/heu_back.sv
// back end: expands commands into output bytes behind an output register
// depends on heu_pkg
module heu_back import heu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  heu_cmd_t head_i,
  input  logic     head_valid_i,
  output logic     head_pop_o,
  input  logic     pop_i,
  output logic     empty_o,
  output heu_out_t out_data_o
);

  logic [2:0] pos_q, pos_d;
  logic [2:0] flush_len, total;
  logic       is_last_byte, load;
  logic [7:0] cur_byte;
  logic       out_valid_q, out_valid_d;
  heu_out_t   out_q;

  // byte selection for the current position of the head command
  assign flush_len    = held_len(head_i.flush_node);
  assign total        = flush_len + {2'b00, head_i.mid_valid};
  assign is_last_byte = (pos_q == total - 3'd1);
  assign cur_byte     = (pos_q < flush_len) ? held_char(head_i.flush_node, pos_q)
                                            : head_i.mid_byte;

  assign load       = head_valid_i && (!out_valid_q || pop_i);
  assign head_pop_o = load && is_last_byte;

  always_comb begin
    pos_d = pos_q;
    if (load) begin
      pos_d = is_last_byte ? 3'd0 : pos_q + 3'd1;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.char_out  <= cur_byte;
      out_q.final_out <= head_i.last && is_last_byte;
    end
  end

  assign empty_o    = !out_valid_q;
  assign out_data_o = out_q;

  // position never runs past the head command
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> pos_q < total)
    else $error("expansion position past command length");

  // with no command at the head the expansion position is back at zero
  a_idle_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_valid_i |-> pos_q == 3'd0)
    else $error("expansion position left over without a command");

endmodule

>>> src/html_entity_unescape_core.sv
// Streaming HTML entity decoder. One text byte is taken per transaction and
// the five entities &amp; &lt; &gt; &quot; &#39; come out as & < > " '; other
// bytes pass through, and a prefix broken by a byte is replayed unchanged. An
// input byte is taken every cycle while the command queue between the trie
// front end and the expander has room; the expander delivers one output byte
// per cycle while its output register is free or popped; a byte that releases
// a held prefix sends the released bytes (up to six) out in turn. Bytes pass
// the command queue and then the output register. end_of_text flushes any held
// prefix and the last output byte of that input carries final_out.
// depends on heu_pkg, heu_front, heu_cmd_fifo, heu_back
module html_entity_unescape_core import heu_pkg::*; #(
  parameter int unsigned CmdDepth = CmdDepthDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push,
  output logic     full,
  input  heu_in_t  in_data_i,
  output logic     empty,
  input  logic     pop,
  output heu_out_t out_data_o
);

  logic     accept;
  logic     cmd_push, cmd_pop, cmd_empty, cmd_full;
  heu_cmd_t cmd, cmd_head;

  assign accept = push && !cmd_full;
  assign full   = cmd_full;

  // trie walk and classification
  heu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .in_data_i  (in_data_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (cmd)
  );

  // decoupling queue
  heu_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .cmd_i   (cmd),
    .pop_i   (cmd_pop),
    .head_o  (cmd_head),
    .empty_o (cmd_empty),
    .full_o  (cmd_full)
  );

  // byte expansion and output register
  heu_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (cmd_head),
    .head_valid_i (!cmd_empty),
    .head_pop_o   (cmd_pop),
    .pop_i        (pop),
    .empty_o      (empty),
    .out_data_o   (out_data_o)
  );

endmodule

>>> sim/tb_top.sv
// self-checking testbench for html_entity_unescape_core: queue-style driver and monitor
// a predictor decodes every accepted byte into the expected output bytes
// depends on heu_pkg and html_entity_unescape_core
`timescale 1ns / 100ps

module tb_top;
  import heu_pkg::*;

  localparam int unsigned StallLimit  = 1000;
  localparam int unsigned SettleCycles = 20;
  localparam int unsigned TextItems   = 330;
  localparam int unsigned ReportMax   = 10;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     push = 1'b0;
  logic     full;
  heu_in_t  in_data_i = '0;
  logic     empty;
  logic     pop = 1'b0;
  heu_out_t out_data_o;

  html_entity_unescape_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_data_i  (in_data_i),
    .empty      (empty),
    .pop        (pop),
    .out_data_o (out_data_o)
  );

  // bytes waiting to be sent and decoded bytes waiting to arrive
  heu_in_t     text_q[$];
  heu_out_t    decoded_q[$];
  heu_node_e   trie_node = ND_IDLE;
  int unsigned fail_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned take_gap = 0;
  bit          send_calm = 1'b0;
  bit          take_calm = 1'b0;

  // completed entities, picked at random for the stimulus
  heu_node_e entity_nodes[5] = '{ND_AMP, ND_LT, ND_GT, ND_QUOT, ND_HASH39};

  // clock
  initial forever #1 clk_i = ~clk_i;

  // text held by each trie node
  function automatic string prefix_of(input heu_node_e n);
    case (n)
      ND_AND:    return "&";
      ND_A:      return "&a";
      ND_AM:     return "&am";
      ND_AMP:    return "&amp";
      ND_L:      return "&l";
      ND_LT:     return "&lt";
      ND_G:      return "&g";
      ND_GT:     return "&gt";
      ND_Q:      return "&q";
      ND_QU:     return "&qu";
      ND_QUO:    return "&quo";
      ND_QUOT:   return "&quot";
      ND_HASH:   return "&#";
      ND_HASH3:  return "&#3";
      ND_HASH39: return "&#39";
      default:   return "";
    endcase
  endfunction

  // character that a ';' turns the node into, zero if the node is not complete
  function automatic logic [7:0] replacement(input heu_node_e n);
    case (n)
      ND_AMP:    return ChAnd;
      ND_LT:     return ChLt;
      ND_GT:     return ChGt;
      ND_QUOT:   return ChDquot;
      ND_HASH39: return ChApos;
      default:   return 8'h00;
    endcase
  endfunction

  // byte that moves a node of depth two or more one step further
  function automatic logic [7:0] wanted_byte(input heu_node_e n);
    string s;
    if (replacement(n) != 8'h00) begin
      return ChSemi;
    end
    s = prefix_of(heu_node_e'(n + 4'd1));
    return s[s.len() - 1];
  endfunction

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic expect_byte(input logic [7:0] c);
    heu_out_t o;
    o.char_out  = c;
    o.final_out = 1'b0;
    decoded_q.push_back(o);
  endtask

  task automatic replay_prefix(input heu_node_e n);
    string s;
    s = prefix_of(n);
    for (int i = 0; i < s.len(); i++) expect_byte(s[i]);
  endtask

  // decode one accepted byte into the expected output bytes
  task automatic decode_byte(input heu_in_t item);
    heu_node_e   nxt;
    bit          took;
    int unsigned start;
    start = decoded_q.size();
    nxt   = ND_IDLE;
    took  = 1'b0;
    if (trie_node == ND_AND) begin
      took = 1'b1;
      case (item.char_in)
        ChA:     nxt = ND_A;
        ChL:     nxt = ND_L;
        ChG:     nxt = ND_G;
        ChQ:     nxt = ND_Q;
        ChHash:  nxt = ND_HASH;
        default: took = 1'b0;
      endcase
    end else if (trie_node != ND_IDLE && item.char_in == wanted_byte(trie_node)) begin
      took = 1'b1;
      if (replacement(trie_node) != 8'h00) begin
        expect_byte(replacement(trie_node));
        nxt = ND_IDLE;
      end else begin
        nxt = heu_node_e'(trie_node + 4'd1);
      end
    end
    // a broken prefix is replayed, then the breaking byte is handled
    if (!took) begin
      replay_prefix(trie_node);
      if (item.char_in == ChAnd) begin
        nxt = ND_AND;
      end else begin
        expect_byte(item.char_in);
        nxt = ND_IDLE;
      end
    end
    // end of text flushes a pending prefix and marks the last byte
    if (item.end_of_text) begin
      replay_prefix(nxt);
      nxt = ND_IDLE;
      if (decoded_q.size() > start) decoded_q[decoded_q.size() - 1].final_out = 1'b1;
    end
    trie_node = nxt;
  endtask

  task automatic add_item(input logic [7:0] c, input bit eot);
    heu_in_t it;
    it.char_in     = c;
    it.end_of_text = eot;
    text_q.push_back(it);
  endtask

  task automatic add_text(input string s, input bit end_here);
    for (int i = 0; i < s.len(); i++) add_item(s[i], end_here && (i == s.len() - 1));
  endtask

  task automatic report(input string msg, input heu_out_t want, input heu_out_t got);
    fail_count++;
    if (fail_count <= ReportMax) begin
      $display("%0t %s: expected char %02h final %0b, got char %02h final %0b", $realtime,
               msg, want.char_out, want.final_out, got.char_out, got.final_out);
    end
  endtask

  // driver: sends pending bytes, with random gaps between transactions
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push      <= 1'b0;
      in_data_i <= '0;
    end else begin
      if (push && !full) begin
        decode_byte(in_data_i);
        void'(text_q.pop_front());
        if ($urandom_range(0, 39) == 0) send_calm = !send_calm;
        send_gap = pick_gap(send_calm);
      end
      if (push && full) begin
        // hold the current transaction
      end else if (send_gap > 0) begin
        send_gap--;
        push <= 1'b0;
      end else if (text_q.size() > 0) begin
        push      <= 1'b1;
        in_data_i <= text_q[0];
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor: takes decoded bytes with random stalls and checks them
  always @(posedge clk_i or negedge rst_ni) begin
    heu_out_t want;
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (decoded_q.size() == 0) begin
          want = '0;
          report("unexpected output byte", want, out_data_o);
        end else begin
          want = decoded_q.pop_front();
          if (out_data_o.char_out != want.char_out || out_data_o.final_out != want.final_out)
            report("output mismatch", want, out_data_o);
        end
        if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
        take_gap = pick_gap(take_calm);
      end
      if (take_gap > 0) begin
        take_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    int unsigned kind;
    int unsigned cut;
    string       s;
    heu_node_e   ent;

    // directed text: longest replay, entity at end, pending prefix at end, edge bytes
    add_text("&quotz", 1'b0);
    add_text("&quot;", 1'b1);
    add_text("&am", 1'b1);
    add_text("&", 1'b1);
    add_text("&&lt;", 1'b0);
    add_item(8'h00, 1'b0);
    add_item(8'h01, 1'b0);
    add_item(8'hff, 1'b1);

    // random text: mostly entities and broken prefixes, the rest plain bytes
    while (text_q.size() < TextItems) begin
      kind = $urandom_range(0, 9);
      ent  = entity_nodes[$urandom_range(0, 4)];
      s    = {prefix_of(ent), ";"};
      if (kind < 4) begin
        for (int i = 0; i < s.len(); i++) add_item(s[i], $urandom_range(0, 19) == 0);
      end else if (kind < 6) begin
        cut = $urandom_range(1, s.len() - 1);
        for (int i = 0; i < cut; i++) add_item(s[i], $urandom_range(0, 19) == 0);
        add_item(8'($urandom_range(1, 255)), $urandom_range(0, 7) == 0);
      end else begin
        add_item(8'($urandom_range(1, 255)), $urandom_range(0, 9) == 0);
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while ((text_q.size() > 0 || decoded_q.size() > 0) && quiet_cycles < StallLimit)
      @(posedge clk_i);

    if (quiet_cycles >= StallLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      repeat (SettleCycles) @(posedge clk_i);
      if (fail_count == 0 && decoded_q.size() == 0) begin
        $display("[ OK ] regression clean");
      end else begin
        $display("[FAIL] regression broken");
      end
      $finish;
    end
  end

endmodule
